// File: hdl/tcp_reply_classifier_assert.svh
`ifndef TCP_REPLY_CLASSIFIER_ASSERT_SVH
`define TCP_REPLY_CLASSIFIER_ASSERT_SVH

// check a property on clock while reset is low
`define TRC_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check a property at every edge of clock, reset included
`define TRC_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hdl/tcp_rc_pkg.sv
`default_nettype none

package tcp_rc_pkg;

   localparam int unsigned RSP_DATA_W = 40;

   localparam logic [3:0] REG_LOCAL_ADDR  = 4'd0;
   localparam logic [3:0] REG_TARGET_ADDR = 4'd1;
   localparam logic [3:0] REG_LOCAL_PORT  = 4'd2;
   localparam logic [3:0] REG_PORT_COUNT  = 4'd3;

   localparam logic [15:0] LOCAL_PORT_RESET = 16'd49152;

   localparam logic [7:0] PROTO_TCP = 8'h06;
   localparam logic [7:0] FLAG_SYN  = 8'h02;
   localparam logic [7:0] FLAG_RST  = 8'h04;
   localparam logic [7:0] FLAG_ACK  = 8'h10;

   localparam logic [6:0] POS_PROTO   = 7'd9;
   localparam logic [6:0] POS_SRC     = 7'd12;
   localparam logic [6:0] POS_DST     = 7'd16;
   localparam logic [6:0] POS_DST_END = 7'd19;
   localparam logic [6:0] COUNT_MAX   = 7'd127;
   localparam logic [6:0] MIN_IP_HDR  = 7'd20;
   localparam logic [7:0] MIN_LEN     = 8'd20;
   localparam logic [7:0] TCP_HDR_LEN = 8'd20;

   localparam logic [6:0] TCP_SPORT_HI = 7'd0;
   localparam logic [6:0] TCP_SPORT_LO = 7'd1;
   localparam logic [6:0] TCP_DPORT_HI = 7'd2;
   localparam logic [6:0] TCP_DPORT_LO = 7'd3;
   localparam logic [6:0] TCP_FLAGS    = 7'd13;

   localparam logic [1:0] ENTRY_FILTERED = 2'd0;
   localparam logic [1:0] ENTRY_OPEN     = 2'd1;
   localparam logic [1:0] ENTRY_CLOSED   = 2'd2;

   localparam logic VERDICT_OPEN   = 1'b0;
   localparam logic VERDICT_CLOSED = 1'b1;

   typedef struct packed {
      logic [31:0] local_address;
      logic [31:0] target_address;
      logic [15:0] local_port;
   } cfg_type;

   typedef struct packed {
      logic        matched;
      logic        verdict;
      logic [15:0] port;
   } reply_type;

endpackage

`default_nettype wire

// File: hdl/tcp_rc_parser.sv
`default_nettype none

module tcp_rc_parser
   import tcp_rc_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      byte_fire,
   input  wire logic [7:0] data_byte,
   input  wire logic      last_byte,
   output reply_type      reply
);

   logic [6:0]       count_ff, count_in;
   logic [6:0]       hdr_ff, hdr_in;
   logic             mis_ff, mis_in;
   logic [15:0]      port_ff, port_in;
   logic [7:0]       flags_ff, flags_in;
   logic [6:0]       tcp_ofs;
   logic             tcp_win;
   logic [7:0]       len;
   logic             len_ok;
   logic             syn_ack;
   logic             rst_set;
   logic [3:0][7:0]  tgt_bytes;
   logic [3:0][7:0]  loc_bytes;

   assign tgt_bytes = cfg.target_address;
   assign loc_bytes = cfg.local_address;

   always_comb begin
      count_in = count_ff;
      hdr_in   = hdr_ff;
      mis_in   = mis_ff;
      port_in  = port_ff;
      flags_in = flags_ff;
      tcp_ofs  = count_ff - hdr_ff;
      tcp_win  = (hdr_ff >= MIN_IP_HDR) && (count_ff >= hdr_ff) && (count_ff != COUNT_MAX);

      if (count_ff == '0) begin
         hdr_in = {1'b0, data_byte[3:0], 2'b00};
      end
      if (count_ff == POS_PROTO && data_byte != PROTO_TCP) begin
         mis_in = 1'b1;
      end
      if (count_ff >= POS_SRC && count_ff < POS_DST
          && data_byte != tgt_bytes[~count_ff[1:0]]) begin
         mis_in = 1'b1;
      end
      if (count_ff >= POS_DST && count_ff <= POS_DST_END
          && data_byte != loc_bytes[~count_ff[1:0]]) begin
         mis_in = 1'b1;
      end

      if (tcp_win) begin
         unique case (tcp_ofs)
            TCP_SPORT_HI: port_in[15:8] = data_byte;
            TCP_SPORT_LO: port_in[7:0]  = data_byte;
            TCP_DPORT_HI: begin
               if (data_byte != cfg.local_port[15:8]) mis_in = 1'b1;
            end
            TCP_DPORT_LO: begin
               if (data_byte != cfg.local_port[7:0]) mis_in = 1'b1;
            end
            TCP_FLAGS:    flags_in = data_byte;
            default: ;
         endcase
      end

      if (count_ff != COUNT_MAX) begin
         count_in = count_ff + 7'd1;
      end

      len     = {1'b0, count_ff} + 8'd1;
      len_ok  = (len >= MIN_LEN) && (hdr_ff >= MIN_IP_HDR)
                && (len >= {1'b0, hdr_ff} + TCP_HDR_LEN) && !mis_in;
      syn_ack = (flags_in & (FLAG_SYN | FLAG_ACK)) == (FLAG_SYN | FLAG_ACK);
      rst_set = (flags_in & FLAG_RST) != 8'h00;

      reply.matched = len_ok && (syn_ack || rst_set);
      reply.verdict = (reply.matched && !syn_ack) ? VERDICT_CLOSED : VERDICT_OPEN;
      reply.port    = reply.matched ? port_in : 16'h0000;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         hdr_ff   <= '0;
         mis_ff   <= 1'b0;
         port_ff  <= '0;
         flags_ff <= '0;
      end else if (byte_fire) begin
         if (last_byte) begin
            count_ff <= '0;
            hdr_ff   <= '0;
            mis_ff   <= 1'b0;
            port_ff  <= '0;
            flags_ff <= '0;
         end else begin
            count_ff <= count_in;
            hdr_ff   <= hdr_in;
            mis_ff   <= mis_in;
            port_ff  <= port_in;
            flags_ff <= flags_in;
         end
      end
   end

endmodule

`default_nettype wire

// File: hdl/tcp_rc_table.sv
`default_nettype none

module tcp_rc_table
   import tcp_rc_pkg::*;
#(
   parameter int unsigned PORT_BITS = 16
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 rd_en,
   input  wire logic [PORT_BITS-1:0] rd_addr,
   output logic [1:0]                rd_data,
   input  wire logic                 wr_en,
   input  wire logic [PORT_BITS-1:0] wr_addr,
   input  wire logic [1:0]           wr_data,
   output logic                      ready
);

   localparam int unsigned DEPTH = 1 << PORT_BITS;

   logic [1:0]           mem [DEPTH];
   logic [1:0]           rd_ff;
   logic                 busy_ff, busy_in;
   logic [PORT_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic                 we;
   logic [PORT_BITS-1:0] wa;
   logic [1:0]           wd;

   always_comb begin
      busy_in     = busy_ff;
      clr_addr_in = clr_addr_ff;
      if (busy_ff) begin
         clr_addr_in = clr_addr_ff + PORT_BITS'(1);
         if (clr_addr_ff == '1) busy_in = 1'b0;
      end
      we = busy_ff || wr_en;
      wa = busy_ff ? clr_addr_ff : wr_addr;
      wd = busy_ff ? ENTRY_FILTERED : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         busy_ff     <= busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // forward a same-cycle write to the read port
   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      if (rd_en) rd_ff <= (we && wa == rd_addr) ? wd : mem[rd_addr];
   end

   assign rd_data = rd_ff;
   assign ready   = !busy_ff;

endmodule

`default_nettype wire

// File: hdl/tcp_reply_classifier.sv
// TCP scan reply classifier.
// req_*: one received IPv4 datagram byte per word in req_tdata[7:0], req_tlast
//   on the final byte. One byte is taken per cycle while req_tready is high.
// rsp_*: one result word per datagram, issued for its last byte, which is
//   registered in the s1 stage and then in the output register.
// csr_*: register writes (index 0 local address, 1 target address, 2 local
//   port, 3 port count, which also loads the pending count); always ready,
//   to be used only while no datagram is in flight.
// Throughput is one byte per cycle while req_tready is high. Each datagram
// reads the verdict table once and a fresh verdict writes it, in a memory
// with one read and one write port (read at the last byte, write as the
// result leaves the s1 stage); matching replies are at least 40 bytes apart.
// Reset clears the valid flags, pending count and parser state, restores the
// configuration defaults and starts a clearing pass over the 2**PORT_BITS
// table entries, with req_tready low; csr writes are taken throughout.
// When rsp_tready is low the result holds in the output register, one more
// result waits in the stage before it, and req_tready drops once both are
// full.
`default_nettype none

module tcp_reply_classifier
   import tcp_rc_pkg::*;
#(
   parameter int unsigned PORT_BITS = 16
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,  // [7:0] data_byte
   input  wire logic                  req_tlast,  // last_byte
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [0] reply_matched, [16:1] probed_port, [17] verdict, [18] newly_decided,
   // [34:19] ports_pending, [39:35] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [3:0]            csr_index,
   input  wire logic [31:0]           csr_data
);

   cfg_type                 cfg_ff;
   logic [15:0]             pending_ff, pending_in;
   reply_type               reply;
   reply_type               s1_ff;
   logic                    s1_valid_ff, s1_valid_in;
   logic                    out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0]   out_data_ff;
   logic                    req_fire;
   logic                    s1_load;
   logic                    s1_move;
   logic                    out_move;
   logic                    fresh;
   logic [1:0]              tbl_rd;
   logic                    tbl_ready;
   logic                    csr_fire;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   assign out_move   = !out_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_move;
   assign req_tready = tbl_ready && (!s1_valid_ff || out_move);
   assign req_fire   = req_tvalid && req_tready;
   assign s1_load    = req_fire && req_tlast;

   tcp_rc_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .byte_fire (req_fire),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .reply     (reply)
   );

   assign fresh = s1_ff.matched && (pending_ff != 16'h0000) && (tbl_rd == ENTRY_FILTERED);

   tcp_rc_table #(
      .PORT_BITS (PORT_BITS)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (s1_load),
      .rd_addr (reply.port[PORT_BITS-1:0]),
      .rd_data (tbl_rd),
      .wr_en   (s1_move && fresh),
      .wr_addr (s1_ff.port[PORT_BITS-1:0]),
      .wr_data ((s1_ff.verdict == VERDICT_CLOSED) ? ENTRY_CLOSED : ENTRY_OPEN),
      .ready   (tbl_ready)
   );

   assign pending_in = pending_ff - {15'b0, fresh};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_load) s1_valid_in = 1'b1;
      else if (s1_move) s1_valid_in = 1'b0;
      out_valid_in = out_valid_ff;
      if (s1_move) out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.local_address  <= '0;
         cfg_ff.target_address <= '0;
         cfg_ff.local_port     <= LOCAL_PORT_RESET;
         pending_ff            <= '0;
         s1_valid_ff           <= 1'b0;
         out_valid_ff          <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_fire && csr_index == REG_PORT_COUNT) begin
            pending_ff <= csr_data[15:0];
         end else if (s1_move) begin
            pending_ff <= pending_in;
         end
         if (csr_fire) begin
            unique case (csr_index)
               REG_LOCAL_ADDR:  cfg_ff.local_address  <= csr_data;
               REG_TARGET_ADDR: cfg_ff.target_address <= csr_data;
               REG_LOCAL_PORT:  cfg_ff.local_port     <= csr_data[15:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) s1_ff <= reply;
      if (s1_move) begin
         out_data_ff <= RSP_DATA_W'({pending_in, fresh, s1_ff.verdict, s1_ff.port,
                                     s1_ff.matched});
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

// File: hdl/tcp_rc_checker.sv
`default_nettype none
`include "tcp_reply_classifier_assert.svh"

module tcp_rc_checker
   import tcp_rc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tready,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic        rsp_stall;
   logic        rsp_matched;
   logic        rsp_fresh;
   logic [17:0] rsp_detail;

   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign rsp_matched = rsp_tdata[0];
   assign rsp_fresh   = rsp_tdata[18];
   assign rsp_detail  = rsp_tdata[18:1];

   `TRC_ASSERT(a_rsp_hold, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata), "held word changed")
   `TRC_ASSERT(a_nomatch, rsp_tvalid && !rsp_matched |-> rsp_detail == '0, "stray fields")
   `TRC_ASSERT(a_fresh_matched, rsp_tvalid && rsp_fresh |-> rsp_matched, "fresh without match")
   `TRC_ASSERT_ALWAYS(a_clear_blocks, reset |=> !req_tready && !rsp_tvalid, "open during clear")

endmodule

bind tcp_reply_classifier tcp_rc_checker u_tcp_rc_checker (.*);

`default_nettype wire
